FILE: rtl/core/cfpr_pkg.sv
// Shared types, constants and helpers for the complementary pitch/roll filter.
// Used by the channel interfaces, the CORDIC unit and the top level.
// No dependencies.
package cfpr_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int ANGLE_FRAC_BITS   = 8;
    localparam int TABLE_LEN         = 24;

    // Field and register widths
    localparam int IN_W    = 16;
    localparam int ANG_W   = 24;
    localparam int GAIN_W  = 16;
    localparam int ALPHA_W = 17;
    localparam int MAG_W   = 17;
    localparam int CFG_W   = 17;
    localparam int CFG_IDX_W = 2;

    // Gain is unsigned Q0.24 held in 16 bits, alpha is unsigned Q1.16
    localparam int GAIN_FRAC  = 24;
    localparam int ALPHA_FRAC = 16;
    localparam int GYRO_SH    = GAIN_FRAC - ANGLE_FRAC_BITS;

    // CORDIC datapath
    localparam int CORDIC_PRESCALE = 8;
    localparam int X_W   = IN_W + CORDIC_PRESCALE + 3;
    localparam int Z_W   = 26;
    localparam int Z_FRAC = 16;
    localparam int Z_SH  = Z_FRAC - ANGLE_FRAC_BITS;
    localparam int ACC_ANG_W = Z_W - Z_SH;
    localparam int ITER_W    = $clog2(CORDIC_ITERATIONS);
    localparam int TAB_IDX_W = $clog2(TABLE_LEN);

    // Shared multiplier
    localparam int MUL_A_W = ANG_W + 1;
    localparam int MUL_B_W = ALPHA_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SUM_W   = PROD_W + 1 - ALPHA_FRAC;

    localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(2560);
    localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(64225);
    localparam logic [MAG_W-1:0]   LOW_RST   = MAG_W'(8192);
    localparam logic [MAG_W-1:0]   HIGH_RST  = MAG_W'(32768);
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GYRO_GAIN   = 2'd0,
        CFG_BLEND_ALPHA = 2'd1,
        CFG_MAG_LOW     = 2'd2,
        CFG_MAG_HIGH    = 2'd3
    } cfg_idx_t;

    // atan(2^-i) in degrees, Q16
    function automatic logic signed [Z_W-1:0] atan_lookup(input logic [TAB_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        begin
            case (idx)
                5'd0:    v = Z_W'(2949120);
                5'd1:    v = Z_W'(1740967);
                5'd2:    v = Z_W'(919879);
                5'd3:    v = Z_W'(466945);
                5'd4:    v = Z_W'(234379);
                5'd5:    v = Z_W'(117304);
                5'd6:    v = Z_W'(58666);
                5'd7:    v = Z_W'(29335);
                5'd8:    v = Z_W'(14668);
                5'd9:    v = Z_W'(7334);
                5'd10:   v = Z_W'(3667);
                5'd11:   v = Z_W'(1833);
                5'd12:   v = Z_W'(917);
                5'd13:   v = Z_W'(458);
                5'd14:   v = Z_W'(229);
                5'd15:   v = Z_W'(115);
                5'd16:   v = Z_W'(57);
                5'd17:   v = Z_W'(29);
                5'd18:   v = Z_W'(14);
                5'd19:   v = Z_W'(7);
                5'd20:   v = Z_W'(4);
                5'd21:   v = Z_W'(2);
                5'd22:   v = Z_W'(1);
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // Clamp to the signed angle range
    function automatic logic signed [ANG_W-1:0] sat_ang(input logic signed [SUM_W-1:0] v);
        logic signed [ANG_W-1:0] r;
        begin
            if ((&v[SUM_W-1:ANG_W-1]) || !(|v[SUM_W-1:ANG_W-1]))
                r = v[ANG_W-1:0];
            else if (v[SUM_W-1])
                r = {1'b1, {(ANG_W-1){1'b0}}};
            else
                r = {1'b0, {(ANG_W-1){1'b1}}};
            return r;
        end
    endfunction

endpackage

FILE: rtl/core/cfpr_if.sv
// Valid/ready channel interfaces: IMU sample in, attitude result out.
// Depends on cfpr_pkg.
interface cfpr_imu_if
    import cfpr_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [IN_W-1:0]  acc_x;
    logic signed [IN_W-1:0]  acc_y;
    logic signed [IN_W-1:0]  acc_z;
    logic signed [IN_W-1:0]  gyro_x;
    logic signed [IN_W-1:0]  gyro_y;

    modport source (output valid, acc_x, acc_y, acc_z, gyro_x, gyro_y, input ready);
    modport sink   (input valid, acc_x, acc_y, acc_z, gyro_x, gyro_y, output ready);
endinterface

interface cfpr_att_if
    import cfpr_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [ANG_W-1:0] pitch_angle;
    logic signed [ANG_W-1:0] roll_angle;
    logic                    accel_applied;

    modport source (output valid, pitch_angle, roll_angle, accel_applied, input ready);
    modport sink   (input valid, pitch_angle, roll_angle, accel_applied, output ready);
endinterface

FILE: rtl/core/complementary_filter_pitch_roll_top.sv
// Complementary pitch/roll filter, top level: sequencer, shared multiplier, state.
// Depends on cfpr_pkg, cfpr_if (cfpr_imu_if, cfpr_att_if) and cfpr_cordic.
//
// Usage:
//   imu  - sink of IMU samples (acc_x/y/z, gyro_x/y); a transfer needs valid and ready.
//   att  - source of results (pitch_angle, roll_angle, accel_applied), one per sample.
//   cfg_write/cfg_index/cfg_data - register writes, taken at any edge with cfg_write
//   high; write only while the filter is idle.
// Sequence: a sample is worked on alone; ready is low from its transfer until its
//   result is loaded into the output register. Without accelerometer correction the
//   sample passes ST_GX, ST_GY, ST_GEND and ST_OUT; with it, ST_GEND is followed by
//   two runs of the single CORDIC unit and, per angle, two passes through the one
//   25x18 multiplier and a blend step, before ST_OUT.
// Flow: ready returns as the result is loaded, so a new sample is taken only once
//   the previous result is in the output register.
// Reset: angles cleared, registers at their defaults, no result pending.
// Stall: a result waits in the output register; the next sample is still taken and
//   processed, and its result is held back until the previous one has gone.
module complementary_filter_pitch_roll_top
    import cfpr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    cfpr_imu_if.sink             imu,
    cfpr_att_if.source           att,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int BL_W = PROD_W + 1;
    localparam logic signed [PROD_W-1:0] GYRO_HALF = PROD_W'(1) <<< (GYRO_SH - 1);
    localparam logic signed [BL_W-1:0]   BL_HALF   = BL_W'(1) <<< (ALPHA_FRAC - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GX,
        ST_GY,
        ST_GEND,
        ST_CORD,
        ST_BL_A,
        ST_BL_B,
        ST_BL_C,
        ST_OUT
    } state_t;

    state_t state_reg;

    logic [GAIN_W-1:0]  gain_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [MAG_W-1:0]   low_reg;
    logic [MAG_W-1:0]   high_reg;

    logic signed [ANG_W-1:0] pitch_reg;
    logic signed [ANG_W-1:0] roll_reg;

    logic signed [IN_W-1:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg;
    logic [MAG_W-1:0]       mag_reg;
    logic                   applied_reg;
    logic                   axis_reg;       // 0: pitch, 1: roll

    logic signed [PROD_W-1:0]    prod_reg, sum_reg;
    logic signed [ACC_ANG_W-1:0] acc_ang_reg;

    logic                    out_valid_reg;
    logic signed [ANG_W-1:0] out_pitch_reg, out_roll_reg;
    logic                    out_applied_reg;

    logic                        cord_start;
    logic signed [IN_W-1:0]      cord_y;
    logic                        cord_done;
    logic signed [ACC_ANG_W-1:0] cord_angle;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_next;

    logic [ALPHA_W-1:0]      alpha_eff, beta;
    logic [MAG_W-1:0]        abs_x, abs_y, abs_z;
    logic signed [PROD_W-1:0] gyro_rnd;
    logic signed [SUM_W-1:0]  gyro_step;
    logic signed [SUM_W-1:0]  pitch_sum, roll_diff;
    logic signed [BL_W-1:0]   bl_sum;
    logic signed [SUM_W-1:0]  bl_res;
    logic signed [ANG_W-1:0]  bl_sat;
    logic signed [ANG_W-1:0]  cur_ang;
    logic                     out_free;

    function automatic logic [MAG_W-1:0] abs_in(input logic signed [IN_W-1:0] v);
        logic signed [MAG_W-1:0] w;
        begin
            w = MAG_W'(v);
            return v[IN_W-1] ? MAG_W'(-w) : MAG_W'(w);
        end
    endfunction

    assign imu.ready = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || att.ready;

    assign alpha_eff = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign beta      = ALPHA_ONE - alpha_eff;
    assign cur_ang   = axis_reg ? roll_reg : pitch_reg;

    assign abs_x = abs_in(ax_reg);
    assign abs_y = abs_in(ay_reg);
    assign abs_z = abs_in(az_reg);

    // shared multiplier, operands picked by the sequencer
    always_comb
    begin
        case (state_reg)
            ST_GX:
            begin
                mul_a = MUL_A_W'(gx_reg);
                mul_b = $signed({{(MUL_B_W-GAIN_W){1'b0}}, gain_reg});
            end
            ST_GY:
            begin
                mul_a = MUL_A_W'(gy_reg);
                mul_b = $signed({{(MUL_B_W-GAIN_W){1'b0}}, gain_reg});
            end
            ST_BL_A:
            begin
                mul_a = MUL_A_W'(cur_ang);
                mul_b = $signed({{(MUL_B_W-ALPHA_W){1'b0}}, alpha_eff});
            end
            ST_BL_B:
            begin
                mul_a = MUL_A_W'(acc_ang_reg);
                mul_b = $signed({{(MUL_B_W-ALPHA_W){1'b0}}, beta});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    assign gyro_rnd  = (prod_reg + GYRO_HALF) >>> GYRO_SH;
    assign gyro_step = SUM_W'(gyro_rnd);
    assign pitch_sum = SUM_W'(pitch_reg) + gyro_step;
    assign roll_diff = SUM_W'(roll_reg) - gyro_step;

    assign bl_sum = BL_W'(sum_reg) + BL_W'(prod_reg) + BL_HALF;
    assign bl_res = SUM_W'(bl_sum >>> ALPHA_FRAC);
    assign bl_sat = sat_ang(bl_res);

    assign cord_start = ((state_reg == ST_GEND) && applied_reg)
                     || ((state_reg == ST_BL_C) && !axis_reg);
    assign cord_y     = (state_reg == ST_GEND) ? ay_reg : ax_reg;

    cfpr_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_start),
        .y_in  (cord_y),
        .x_in  (az_reg),
        .done  (cord_done),
        .angle (cord_angle)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            gain_reg        <= GAIN_RST;
            alpha_reg       <= ALPHA_RST;
            low_reg         <= LOW_RST;
            high_reg        <= HIGH_RST;
            pitch_reg       <= '0;
            roll_reg        <= '0;
            ax_reg          <= '0;
            ay_reg          <= '0;
            az_reg          <= '0;
            gx_reg          <= '0;
            gy_reg          <= '0;
            mag_reg         <= '0;
            applied_reg     <= 1'b0;
            axis_reg        <= 1'b0;
            prod_reg        <= '0;
            sum_reg         <= '0;
            acc_ang_reg     <= '0;
            out_valid_reg   <= 1'b0;
            out_pitch_reg   <= '0;
            out_roll_reg    <= '0;
            out_applied_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_GYRO_GAIN:   gain_reg  <= cfg_data[GAIN_W-1:0];
                    CFG_BLEND_ALPHA: alpha_reg <= cfg_data[ALPHA_W-1:0];
                    CFG_MAG_LOW:     low_reg   <= cfg_data[MAG_W-1:0];
                    CFG_MAG_HIGH:    high_reg  <= cfg_data[MAG_W-1:0];
                    default:         ;
                endcase
            end

            // in ST_OUT the output register is reloaded below instead
            if (out_valid_reg && att.ready && (state_reg != ST_OUT))
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (imu.valid)
                    begin
                        ax_reg    <= imu.acc_x;
                        ay_reg    <= imu.acc_y;
                        az_reg    <= imu.acc_z;
                        gx_reg    <= imu.gyro_x;
                        gy_reg    <= imu.gyro_y;
                        state_reg <= ST_GX;
                    end
                end
                ST_GX:
                begin
                    prod_reg  <= prod_next;
                    mag_reg   <= abs_x + abs_y + abs_z;
                    state_reg <= ST_GY;
                end
                ST_GY:
                begin
                    pitch_reg   <= sat_ang(pitch_sum);
                    prod_reg    <= prod_next;
                    applied_reg <= (mag_reg > low_reg) && (mag_reg < high_reg);
                    state_reg   <= ST_GEND;
                end
                ST_GEND:
                begin
                    roll_reg <= sat_ang(roll_diff);
                    axis_reg <= 1'b0;
                    if (applied_reg)
                        state_reg <= ST_CORD;
                    else
                        state_reg <= ST_OUT;
                end
                ST_CORD:
                begin
                    if (cord_done)
                    begin
                        acc_ang_reg <= cord_angle;
                        state_reg   <= ST_BL_A;
                    end
                end
                ST_BL_A:
                begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_BL_B;
                end
                ST_BL_B:
                begin
                    sum_reg   <= prod_reg;
                    prod_reg  <= prod_next;
                    state_reg <= ST_BL_C;
                end
                ST_BL_C:
                begin
                    if (axis_reg)
                    begin
                        roll_reg  <= bl_sat;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        // pitch done, roll CORDIC starts this cycle
                        pitch_reg <= bl_sat;
                        axis_reg  <= 1'b1;
                        state_reg <= ST_CORD;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_pitch_reg   <= pitch_reg;
                        out_roll_reg    <= roll_reg;
                        out_applied_reg <= applied_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign att.valid         = out_valid_reg;
    assign att.pitch_angle   = out_pitch_reg;
    assign att.roll_angle    = out_roll_reg;
    assign att.accel_applied = out_applied_reg;

endmodule

FILE: rtl/core/cfpr_cordic.sv
// Iterative vectoring CORDIC: atan2(y, x) in degrees, one micro-rotation per cycle.
// Depends on cfpr_pkg.
module cfpr_cordic
    import cfpr_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [IN_W-1:0]      y_in,
    input  logic signed [IN_W-1:0]      x_in,
    output logic                        done,
    output logic signed [ACC_ANG_W-1:0] angle
);

    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERATIONS - 1);
    localparam logic signed [Z_W-1:0] Z_RIGHT = Z_W'(90 * 65536);
    localparam logic signed [Z_W-1:0] Z_HALF  = Z_W'(1) <<< (Z_SH - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  zero_reg, zero_next;
    logic [ITER_W-1:0]     iter_reg, iter_next;
    logic signed [X_W-1:0] x_reg, x_next;
    logic signed [X_W-1:0] y_reg, y_next;
    logic signed [Z_W-1:0] z_reg, z_next;

    logic signed [X_W-1:0] x_sc, y_sc, xs, ys;
    logic signed [Z_W-1:0] step_ang, z_rnd;

    assign x_sc     = X_W'(x_in) <<< CORDIC_PRESCALE;
    assign y_sc     = X_W'(y_in) <<< CORDIC_PRESCALE;
    assign xs       = x_reg >>> iter_reg;
    assign ys       = y_reg >>> iter_reg;
    assign step_ang = atan_lookup(TAB_IDX_W'(iter_reg));

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        zero_next = zero_reg;
        iter_next = iter_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start)
        begin
            busy_next = 1'b1;
            iter_next = '0;
            zero_next = (x_in == '0) && (y_in == '0);
            if (x_in < 0)
            begin
                // left half plane: rotate by a quarter turn first
                if (y_in >= 0)
                begin
                    z_next = Z_RIGHT;
                    x_next = y_sc;
                    y_next = -x_sc;
                end
                else
                begin
                    z_next = -Z_RIGHT;
                    x_next = -y_sc;
                    y_next = x_sc;
                end
            end
            else
            begin
                z_next = '0;
                x_next = x_sc;
                y_next = y_sc;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + step_ang;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - step_ang;
            end
            iter_next = iter_reg + 1'b1;
            if (iter_reg == ITER_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            zero_reg <= 1'b0;
            iter_reg <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            zero_reg <= zero_next;
            iter_reg <= iter_next;
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
        end
    end

    // round half up to the output fraction bits
    assign z_rnd = (z_reg + Z_HALF) >>> Z_SH;
    assign done  = done_reg;
    assign angle = zero_reg ? '0 : z_rnd[ACC_ANG_W-1:0];

endmodule
